// ===== hdl/qrr_pkg.sv =====
`timescale 1ns / 1ps

package qrr_pkg;

   // Coefficient and result widths
   localparam int COEF_W = 16;
   localparam int ROOT_W = 32;

   // Discriminant and square root
   localparam int DELTA_W = 35;
   localparam int RAD_W   = 34;
   localparam int SQ_W    = RAD_W / 2;
   localparam int SQREM_W = SQ_W + 3;
   localparam int SQ_STEPS = SQ_W;

   // Divider: magnitude of numerator, 2A divisor, long quotient
   localparam int NUM_W   = SQ_W + 2;
   localparam int MAG_W   = NUM_W - 1;
   localparam int FRAC_W  = 16;
   localparam int DVD_W   = MAG_W + FRAC_W;
   localparam int DEN_W   = COEF_W + 1;
   localparam int DV_STEPS = DVD_W;

   // Start to result strobe, in cycles
   localparam int RSP_LATENCY = SQ_STEPS + DV_STEPS + 5;

   typedef enum logic [1:0] {
      ST_NONE   = 2'd0,
      ST_ONE    = 2'd1,
      ST_TWO    = 2'd2,
      ST_A_ZERO = 2'd3
   } status_type;

   typedef struct packed {
      logic                      valid;
      status_type                status;
      logic signed [COEF_W-1:0]  a;
      logic signed [COEF_W-1:0]  b;
      logic [RAD_W-1:0]          rad;
      logic [SQREM_W-1:0]        rem;
      logic [SQ_W-1:0]           root;
   } sq_stage_type;

   typedef struct packed {
      logic               neg;
      logic [DVD_W-1:0]   dvd;
      logic [DEN_W-1:0]   rem;
      logic [DVD_W-1:0]   quo;
   } dv_lane_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [DEN_W-1:0]  den;
      dv_lane_type       plus;
      dv_lane_type       minus;
   } dv_stage_type;

   // One restoring long-division step
   function automatic dv_lane_type dv_step(dv_lane_type s, logic [DEN_W-1:0] den);
      dv_lane_type       r;
      logic [DEN_W:0]    trial;
      r = s;
      trial = {s.rem, s.dvd[DVD_W-1]};
      r.dvd = {s.dvd[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         trial = trial - {1'b0, den};
         r.quo = {s.quo[DVD_W-2:0], 1'b1};
      end else begin
         r.quo = {s.quo[DVD_W-2:0], 1'b0};
      end
      r.rem = trial[DEN_W-1:0];
      return r;
   endfunction

   // Apply sign and saturate to signed 32 bits
   function automatic logic [ROOT_W-1:0] sat_q(logic neg, logic [DVD_W-1:0] q);
      logic [ROOT_W-1:0] r;
      if (!neg) begin
         if (q[DVD_W-1:ROOT_W-1] != '0) r = {1'b0, {(ROOT_W-1){1'b1}}};
         else r = q[ROOT_W-1:0];
      end else begin
         if (q > {{(DVD_W-ROOT_W){1'b0}}, 1'b1, {(ROOT_W-1){1'b0}}})
            r = {1'b1, {(ROOT_W-1){1'b0}}};
         else r = ROOT_W'(0) - q[ROOT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/quadratic_real_roots.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// input     req_coef_a, req_coef_b, req_coef_c      start while busy is low
// result    rsp_root_status, rsp_root_plus/minus    rsp_valid for one cycle
//
// One item enters every cycle; busy stays low.
// Each item passes in order through the input, product and
// discriminant stages, 17 square root stages (two radicand bits each),
// one numerator stage, 34 divider stages (one quotient bit each), one output stage.
// Reset clears the valid bits of all stages; data registers are not cleared.
// The receiver cannot stall, so the pipeline never holds.
module quadratic_real_roots (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [qrr_pkg::COEF_W-1:0]  req_coef_a,
   input  logic signed [qrr_pkg::COEF_W-1:0]  req_coef_b,
   input  logic signed [qrr_pkg::COEF_W-1:0]  req_coef_c,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_root_status,
   output logic signed [qrr_pkg::ROOT_W-1:0]  rsp_root_plus,
   output logic signed [qrr_pkg::ROOT_W-1:0]  rsp_root_minus
);
   import qrr_pkg::*;

   // Input stage
   logic                      in_valid_ff;
   logic signed [COEF_W-1:0]  in_a_ff, in_b_ff, in_c_ff;

   // Product stage
   logic                        pr_valid_ff;
   logic signed [COEF_W-1:0]    pr_a_ff, pr_b_ff;
   logic signed [2*COEF_W-1:0]  pr_bb_ff, pr_ac_ff;

   logic signed [DELTA_W-1:0]   delta;
   sq_stage_type                sq_ff [0:SQ_STEPS];
   sq_stage_type                sq_in [0:SQ_STEPS];
   dv_stage_type                dv_ff [0:DV_STEPS];
   dv_stage_type                dv_in [0:DV_STEPS];

   logic                        rsp_valid_ff;
   status_type                  rsp_status_ff;
   logic [ROOT_W-1:0]           rsp_plus_ff, rsp_minus_ff;

   assign busy = 1'b0;

   // Discriminant, status and radicand
   always_comb begin
      delta = $signed({3'b000, pr_bb_ff}) - $signed({pr_ac_ff[2*COEF_W-1], pr_ac_ff, 2'b00});
      sq_in[0].valid = pr_valid_ff && !reset;
      sq_in[0].a = pr_a_ff;
      sq_in[0].b = pr_b_ff;
      sq_in[0].rem = '0;
      sq_in[0].root = '0;
      sq_in[0].rad = '0;
      if (pr_a_ff == '0) begin
         sq_in[0].status = ST_A_ZERO;
      end else if (delta[DELTA_W-1]) begin
         sq_in[0].status = ST_NONE;
      end else if (delta == '0) begin
         sq_in[0].status = ST_ONE;
      end else begin
         sq_in[0].status = ST_TWO;
         sq_in[0].rad = delta[RAD_W-1:0];
      end
   end

   // Square root: one root bit per stage
   genvar i;
   for (i = 0; i < SQ_STEPS; i++) begin : g_sq
      logic [SQREM_W-1:0] trial;
      logic [SQREM_W-1:0] test;
      always_comb begin
         trial = {sq_ff[i].rem[SQREM_W-3:0], sq_ff[i].rad[RAD_W-1 -: 2]};
         test = {{(SQREM_W-SQ_W-2){1'b0}}, sq_ff[i].root, 2'b01};
         sq_in[i+1] = sq_ff[i];
         sq_in[i+1].valid = sq_ff[i].valid && !reset;
         sq_in[i+1].rad = {sq_ff[i].rad[RAD_W-3:0], 2'b00};
         if (trial >= test) begin
            sq_in[i+1].rem = trial - test;
            sq_in[i+1].root = {sq_ff[i].root[SQ_W-2:0], 1'b1};
         end else begin
            sq_in[i+1].rem = trial;
            sq_in[i+1].root = {sq_ff[i].root[SQ_W-2:0], 1'b0};
         end
      end
   end

   // Numerators -B +/- root, their signs and magnitudes, and |2A|
   logic signed [NUM_W-1:0] neg_b, num_p, num_m;
   logic [COEF_W-1:0]       abs_a;
   always_comb begin
      neg_b = NUM_W'(0) - NUM_W'(sq_ff[SQ_STEPS].b);
      num_p = neg_b + $signed({2'b00, sq_ff[SQ_STEPS].root});
      num_m = neg_b - $signed({2'b00, sq_ff[SQ_STEPS].root});
      abs_a = sq_ff[SQ_STEPS].a[COEF_W-1] ? COEF_W'(0) - sq_ff[SQ_STEPS].a
                                          : sq_ff[SQ_STEPS].a;
      dv_in[0].valid = sq_ff[SQ_STEPS].valid && !reset;
      dv_in[0].status = sq_ff[SQ_STEPS].status;
      dv_in[0].den = {abs_a, 1'b0};
      dv_in[0].plus.neg = num_p[NUM_W-1] ^ sq_ff[SQ_STEPS].a[COEF_W-1];
      dv_in[0].plus.dvd = {(num_p[NUM_W-1] ? MAG_W'(-num_p) : num_p[MAG_W-1:0]),
                           {FRAC_W{1'b0}}};
      dv_in[0].plus.rem = '0;
      dv_in[0].plus.quo = '0;
      dv_in[0].minus.neg = num_m[NUM_W-1] ^ sq_ff[SQ_STEPS].a[COEF_W-1];
      dv_in[0].minus.dvd = {(num_m[NUM_W-1] ? MAG_W'(-num_m) : num_m[MAG_W-1:0]),
                            {FRAC_W{1'b0}}};
      dv_in[0].minus.rem = '0;
      dv_in[0].minus.quo = '0;
   end

   // Divider: one quotient bit per stage in both lanes
   for (i = 0; i < DV_STEPS; i++) begin : g_dv
      always_comb begin
         dv_in[i+1] = dv_ff[i];
         dv_in[i+1].valid = dv_ff[i].valid && !reset;
         dv_in[i+1].plus = dv_step(dv_ff[i].plus, dv_ff[i].den);
         dv_in[i+1].minus = dv_step(dv_ff[i].minus, dv_ff[i].den);
      end
   end

   // Advance every stage each cycle
   always_ff @(posedge clock) begin
      in_a_ff <= req_coef_a;
      in_b_ff <= req_coef_b;
      in_c_ff <= req_coef_c;
      pr_a_ff <= in_a_ff;
      pr_b_ff <= in_b_ff;
      pr_bb_ff <= in_b_ff * in_b_ff;
      pr_ac_ff <= in_a_ff * in_c_ff;
      for (int k = 0; k <= SQ_STEPS; k++) sq_ff[k] <= sq_in[k];
      for (int k = 0; k <= DV_STEPS; k++) dv_ff[k] <= dv_in[k];
      rsp_status_ff <= dv_ff[DV_STEPS].status;
      rsp_plus_ff <= (dv_ff[DV_STEPS].status == ST_ONE || dv_ff[DV_STEPS].status == ST_TWO)
                     ? sat_q(dv_ff[DV_STEPS].plus.neg, dv_ff[DV_STEPS].plus.quo) : '0;
      rsp_minus_ff <= (dv_ff[DV_STEPS].status == ST_TWO)
                      ? sat_q(dv_ff[DV_STEPS].minus.neg, dv_ff[DV_STEPS].minus.quo) : '0;
      if (reset) begin
         in_valid_ff <= 1'b0;
         pr_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
         pr_valid_ff <= in_valid_ff;
         rsp_valid_ff <= dv_ff[DV_STEPS].valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_root_status = rsp_status_ff;
   assign rsp_root_plus = rsp_plus_ff;
   assign rsp_root_minus = rsp_minus_ff;

   // Every accepted item comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(RSP_LATENCY) rsp_valid)
      else $error("result strobe missing after latency");

   // No result without an item accepted at the matching edge
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, RSP_LATENCY))
      else $error("result strobe without item");

   // Zero A and negative discriminant give no roots
   a_empty_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_status == ST_A_ZERO || rsp_root_status == ST_NONE)
      |-> rsp_root_plus == '0 && rsp_root_minus == '0)
      else $error("root fields set without roots");

   // Single root leaves the minus field clear
   a_single_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_status == ST_ONE |-> rsp_root_minus == '0)
      else $error("minus root set for single root");

endmodule
